/* rtl/fcr_pkg.sv */
// Shared types, character codes and result codes for the framed command receiver.
// Used by framed_command_receiver; depends on nothing else.
package fcr_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_ECHO     = 2'd0;
  localparam logic [1:0] KIND_COLOR    = 2'd1;
  localparam logic [1:0] KIND_MODE     = 2'd2;
  localparam logic [1:0] KIND_OVERFLOW = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_START_MARKER = 1'b0;
  localparam logic CFG_END_MARKER   = 1'b1;

  // Characters that the parser recognises.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  // Value of a byte that is no digit in any base used here.
  localparam logic [4:0] NOT_DIGIT = 5'd31;

  // Magnitude clamps at 2^32, so it needs 33 bits.
  localparam logic [32:0] MAG_LIMIT = 33'h1_0000_0000;

  typedef logic [32:0] mag_t;
  typedef logic [36:0] acc_t;

  function automatic logic [4:0] digit_val(input logic [7:0] c);
    logic [4:0] v;
    begin
      v = NOT_DIGIT;
      if (c >= CH_ZERO && c <= CH_NINE) v = 5'(c - CH_ZERO);
      else if (c >= CH_LA && c <= CH_LF) v = 5'(c - CH_LA) + 5'd10;
      else if (c >= CH_UA && c <= CH_UF) v = 5'(c - CH_UA) + 5'd10;
      return v;
    end
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

/* rtl/fcr_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the frame buffer of the framed command receiver.
module fcr_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/framed_command_receiver.sv */
// Framed command receiver: takes one received byte per transfer. Outside a frame a byte
// equal to start_marker opens a frame and any other byte is echoed back as a result. Inside
// a frame bytes are stored in a BUFFER_BYTES deep buffer; filling its last slot reports an
// overflow, and later bytes overwrite that slot. The end_marker closes the frame and starts
// a walk of the buffer: a type byte 'C' gives a colour from a hexadecimal number, 'M' a mode
// from a decimal number, anything else gives no result. Parsing stops after at most
// BUFFER_BYTES buffer bytes have been read; the buffer RAM delivers one byte a cycle and one
// shared multiply-accumulate unit folds one digit a cycle into the value. The byte input is
// not ready during the walk or while a result waits in the output register.
// Depends on fcr_pkg and fcr_ram.
module framed_command_receiver
  import fcr_pkg::*;
#(
  parameter int BUFFER_BYTES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         result_kind,
  output logic [7:0]         echo_byte,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic signed [31:0] mode_value
);

  localparam int IDX_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUFFER_BYTES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam logic [2:0] PH_TYPE = 3'd0;
  localparam logic [2:0] PH_LEAD = 3'd1;
  localparam logic [2:0] PH_NUM0 = 3'd2;
  localparam logic [2:0] PH_PRE0 = 3'd3;
  localparam logic [2:0] PH_PREX = 3'd4;
  localparam logic [2:0] PH_DIG  = 3'd5;

  logic [1:0]       state;
  logic [2:0]       phase;
  logic [2:0]       phase_next;
  logic             in_frame;
  logic [IDX_W-1:0] write_index;
  logic [IDX_W-1:0] rd_ptr;
  logic             rd_valid;
  logic             neg;
  logic             neg_next;
  logic             base16;
  logic             base16_next;
  mag_t             mag;
  mag_t             mag_next;
  logic [7:0]       start_marker;
  logic [7:0]       end_marker;

  logic             in_xfer;
  logic             out_free;
  logic             wr_en;
  logic [7:0]       wr_data;
  logic             rd_en;
  logic [7:0]       ram_rdata;

  logic [4:0]       dval;
  logic             is_dig;
  acc_t             acc_sum;
  mag_t             acc_sat;
  logic             parse_done;
  logic             parse_drop;
  logic             big;
  logic [31:0]      final_val;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && out_free;
  assign in_xfer   = in_valid && in_ready;

  // Stores go to the RAM only inside a frame; the end marker stores the terminator.
  assign wr_en   = in_xfer && in_frame;
  assign wr_data = (rx_byte == end_marker) ? CH_NUL : rx_byte;
  assign rd_en   = (state == S_WALK);

  fcr_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES),
    .ADDR_W(IDX_W)
  ) u_buf (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(write_index),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_ptr),
    .rd_data(ram_rdata)
  );

  // Shared digit unit: mag * base + digit, clamped at 2^32.
  always_comb begin
    dval   = digit_val(ram_rdata);
    is_dig = base16 ? (dval < 5'd16) : (dval < 5'd10);
    if (base16) begin
      acc_sum = {mag, 4'b0000} + acc_t'(dval);
    end else begin
      acc_sum = acc_t'({mag, 3'b000}) + acc_t'({mag, 1'b0}) + acc_t'(dval);
    end
    acc_sat = (acc_sum > acc_t'(MAG_LIMIT)) ? MAG_LIMIT : acc_sum[32:0];
  end

  // One buffer byte per cycle through the number syntax.
  always_comb begin
    phase_next  = phase;
    neg_next    = neg;
    base16_next = base16;
    mag_next    = mag;
    parse_done  = 1'b0;
    parse_drop  = 1'b0;
    unique case (phase)
      PH_TYPE: begin
        if (ram_rdata == CH_C) begin
          base16_next = 1'b1;
          phase_next  = PH_LEAD;
        end else if (ram_rdata == CH_M) begin
          base16_next = 1'b0;
          phase_next  = PH_LEAD;
        end else begin
          parse_drop = 1'b1;
        end
      end
      PH_LEAD, PH_NUM0: begin
        if (phase == PH_LEAD && is_blank(ram_rdata)) begin
          phase_next = PH_LEAD;
        end else if (phase == PH_LEAD &&
                     (ram_rdata == CH_PLUS || ram_rdata == CH_MINUS)) begin
          neg_next   = (ram_rdata == CH_MINUS);
          phase_next = PH_NUM0;
        end else if (base16 && ram_rdata == CH_ZERO) begin
          // A leading zero may open a 0x prefix; the magnitude is still zero.
          phase_next = PH_PRE0;
        end else if (is_dig) begin
          mag_next   = acc_sat;
          phase_next = PH_DIG;
        end else begin
          parse_done = 1'b1;
        end
      end
      PH_PRE0: begin
        if (ram_rdata == CH_LX || ram_rdata == CH_UX) begin
          phase_next = PH_PREX;
        end else if (is_dig) begin
          mag_next   = acc_sat;
          phase_next = PH_DIG;
        end else begin
          parse_done = 1'b1;
        end
      end
      PH_PREX, PH_DIG: begin
        // After 0x with no hex digit the value is the leading zero alone.
        if (is_dig) begin
          mag_next   = acc_sat;
          phase_next = PH_DIG;
        end else begin
          parse_done = 1'b1;
        end
      end
      default: begin
        parse_drop = 1'b1;
      end
    endcase
  end

  // Saturation to 32-bit two's complement.
  always_comb begin
    big = (mag[32:31] != 2'b00);
    if (neg) begin
      final_val = big ? 32'h8000_0000 : (32'd0 - mag[31:0]);
    end else begin
      final_val = big ? 32'h7FFF_FFFF : mag[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      in_frame     <= 1'b0;
      write_index  <= '0;
      rd_valid     <= 1'b0;
      out_valid    <= 1'b0;
      start_marker <= 8'd60;
      end_marker   <= 8'd62;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_START_MARKER: start_marker <= cfg_data;
          CFG_END_MARKER:   end_marker   <= cfg_data;
          default:          start_marker <= start_marker;
        endcase
      end

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (!in_frame) begin
              if (rx_byte == start_marker) begin
                in_frame <= 1'b1;
              end else begin
                out_valid   <= 1'b1;
                result_kind <= KIND_ECHO;
                echo_byte   <= rx_byte;
                red         <= 8'd0;
                green       <= 8'd0;
                blue        <= 8'd0;
                mode_value  <= 32'sd0;
              end
            end else if (rx_byte != end_marker) begin
              if (write_index == LAST_IDX) begin
                out_valid   <= 1'b1;
                result_kind <= KIND_OVERFLOW;
                echo_byte   <= 8'd0;
                red         <= 8'd0;
                green       <= 8'd0;
                blue        <= 8'd0;
                mode_value  <= 32'sd0;
              end else begin
                write_index <= write_index + 1'b1;
              end
            end else begin
              in_frame    <= 1'b0;
              write_index <= '0;
              state       <= S_WALK;
              rd_ptr      <= '0;
              rd_valid    <= 1'b0;
              phase       <= PH_TYPE;
              neg         <= 1'b0;
              mag         <= '0;
            end
          end
        end
        S_WALK: begin
          // The read pointer runs one byte ahead of the byte being parsed.
          rd_ptr   <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
          rd_valid <= 1'b1;
          if (rd_valid) begin
            phase  <= phase_next;
            neg    <= neg_next;
            base16 <= base16_next;
            mag    <= mag_next;
            if (parse_drop) begin
              state <= S_IDLE;
            end else if (parse_done) begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            echo_byte <= 8'd0;
            if (base16) begin
              result_kind <= KIND_COLOR;
              red         <= final_val[23:16];
              green       <= final_val[15:8];
              blue        <= final_val[7:0];
              mode_value  <= 32'sd0;
            end else begin
              result_kind <= KIND_MODE;
              red         <= 8'd0;
              green       <= 8'd0;
              blue        <= 8'd0;
              mode_value  <= $signed(final_val);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    write_index <= LAST_IDX)
    else $error("write index beyond the last buffer slot");

  a_walk_outside_frame: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK || state == S_FIN) |-> (!in_frame && write_index == '0))
    else $error("buffer walk while a frame is still open");

  a_overflow_reported: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && in_frame && rx_byte != end_marker && write_index == LAST_IDX)
    |=> (out_valid && result_kind == KIND_OVERFLOW))
    else $error("store into the last slot gave no overflow result");

  a_number_from_walk: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid) && (result_kind == KIND_COLOR || result_kind == KIND_MODE))
    |-> ($past(state) == S_FIN))
    else $error("number result not produced by the buffer walk");

endmodule
